### hdl/grpw_pkg.sv
// grpw_pkg: shared types and constants of the gray raster pixel writer
// no dependencies; imported by every module of the block

package grpw_pkg;

  localparam int ADDR_W      = 30;
  localparam int PITCH_W     = 14;
  localparam int DIM_W       = 12;
  localparam int BPP_W       = 6;
  localparam int GRAY_W      = 8;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int BYTE_IDX_W  = 2;
  localparam int OUT_TDATA_W = 40;

  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 4;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 3'd4;

  localparam logic [ADDR_W-1:0]  BASE_RST   = '0;
  localparam logic [PITCH_W-1:0] PITCH_RST  = 14'd1024;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 12'd480;
  localparam logic [BPP_W-1:0]   BPP_RST    = 6'd8;

  // supported depths
  localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
  localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
  localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  localparam logic [BYTE_W-1:0] ALPHA_BYTE  = 8'hFF;
  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h7F;

  typedef enum logic [2:0] {
    FMT_GRAY8  = 3'd0,
    FMT_RGB565 = 3'd1,
    FMT_BGR24  = 3'd2,
    FMT_BGRA32 = 3'd3,
    FMT_MARKER = 3'd4
  } pix_fmt_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [PITCH_W-1:0] pitch;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [BPP_W-1:0]   bpp;
  } cfg_t;

  // one classified pixel waiting for its byte writes
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [GRAY_W-1:0] gray;
    pix_fmt_e          fmt;
    logic              eof;
  } pix_cmd_t;

endpackage

### hdl/grpw_front.sv
// grpw_front: accepts gray pixels, tracks raster position, classifies depth
// and forms the pixel start address; depends on grpw_pkg

module grpw_front import grpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              pix_valid_i,
  output logic              pix_ready_o,
  input  logic [GRAY_W-1:0] pix_gray_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output pix_cmd_t          cmd_o
);

  localparam int CmpW    = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
  localparam int LineMulW = PITCH_W + COORD_BITS;
  localparam int OffMulW  = COORD_BITS + 3;

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [COORD_BITS:0]   col_inc, row_inc;
  logic                  line_end, frame_end, accept;

  logic                  a_valid_q, a_valid_d;
  logic [ADDR_W-1:0]     line_off_q, pix_off_q;
  logic [GRAY_W-1:0]     gray_q;
  pix_fmt_e              fmt_q, fmt_d;
  logic                  eof_q;

  logic [LineMulW-1:0]   line_prod;
  logic [OffMulW-1:0]    pix_prod;

  assign pix_ready_o = !a_valid_q || cmd_ready_i;
  assign accept      = pix_valid_i && pix_ready_o;

  assign col_inc   = {1'b0, col_q} + 1'b1;
  assign row_inc   = {1'b0, row_q} + 1'b1;
  assign line_end  = CmpW'(col_inc) >= CmpW'(cfg_i.width);
  assign frame_end = line_end && (CmpW'(row_inc) >= CmpW'(cfg_i.height));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (line_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_inc[COORD_BITS-1:0];
      end else begin
        col_d = col_inc[COORD_BITS-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_i.bpp)
      BPP_8:   fmt_d = FMT_GRAY8;
      BPP_16:  fmt_d = FMT_RGB565;
      BPP_24:  fmt_d = FMT_BGR24;
      BPP_32:  fmt_d = FMT_BGRA32;
      default: fmt_d = FMT_MARKER;
    endcase
  end

  // byte offset into the line is column times bpp/8, rounded down, for every depth
  assign line_prod = LineMulW'(cfg_i.pitch) * LineMulW'(row_q);
  assign pix_prod  = OffMulW'(col_q) * OffMulW'(cfg_i.bpp[BPP_W-1:3]);

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_off_q <= ADDR_W'(line_prod);
      pix_off_q  <= ADDR_W'(pix_prod);
      gray_q     <= pix_gray_i;
      fmt_q      <= fmt_d;
      eof_q      <= frame_end;
    end
  end

  assign cmd_valid_o = a_valid_q;
  assign cmd_o.addr  = cfg_i.base + line_off_q + pix_off_q;
  assign cmd_o.gray  = gray_q;
  assign cmd_o.fmt   = fmt_q;
  assign cmd_o.eof   = eof_q;

endmodule

### hdl/grpw_fifo.sv
// grpw_fifo: short command queue between front and back
// depends on grpw_pkg for the command type

module grpw_fifo import grpw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  pix_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output pix_cmd_t pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  pix_cmd_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/grpw_back.sv
// grpw_back: expands one queued pixel into its byte writes, one per cycle while
// the output is not stalled, into a registered output stage; depends on grpw_pkg

module grpw_back import grpw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  pix_cmd_t          cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o,
  output logic              out_eof_o
);

  logic [BYTE_IDX_W-1:0] idx_q, idx_d, last_idx;
  logic                  load, is_last;
  logic [BYTE_W-1:0]     byte_d;
  logic [GRAY_W-1:0]     g;

  logic                  out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]     out_addr_q;
  logic [BYTE_W-1:0]     out_byte_q;
  logic                  out_last_q, out_eof_q;

  assign g = cmd_i.gray;

  always_comb begin
    case (cmd_i.fmt)
      FMT_RGB565: last_idx = 2'd1;
      FMT_BGR24:  last_idx = 2'd2;
      FMT_BGRA32: last_idx = 2'd3;
      default:    last_idx = 2'd0;
    endcase
  end

  always_comb begin
    byte_d = g;
    case (cmd_i.fmt)
      FMT_RGB565: begin
        // low byte carries green low bits and blue, high byte red and green high
        byte_d = (idx_q == 2'd0) ? {g[4:2], g[7:3]} : {g[7:3], g[7:5]};
      end
      FMT_BGRA32: begin
        if (idx_q == 2'd3) begin
          byte_d = ALPHA_BYTE;
        end
      end
      FMT_MARKER: byte_d = MARKER_BYTE;
      default:    byte_d = g;
    endcase
  end

  assign load        = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign is_last     = idx_q == last_idx;
  assign cmd_ready_o = load && is_last;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_addr_q <= cmd_i.addr + ADDR_W'(idx_q);
      out_byte_q <= byte_d;
      out_last_q <= is_last;
      out_eof_q  <= cmd_i.eof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_eof_o   = out_eof_q;

endmodule

### hdl/gray_raster_pixel_writer.sv
// gray_raster_pixel_writer: top level with configuration registers,
// front, command queue and byte writer; depends on grpw_pkg and grpw_* modules
//
// Usage:
// - s_axis carries one 8-bit gray pixel per request in raster order. Each pixel
//   becomes one to four byte write requests on m_axis (address, byte, last of
//   pixel on tlast, end of frame on tuser) at base + pitch * row + column *
//   bytes per pixel.
// - Throughput: one byte write per cycle unless m_axis_tready stalls; a pixel is
//   one byte at 8 bpp and other depths, two at 16, three at 24 and four at 32 bpp;
//   the single-byte output register of the back end sets that rate.
// - The first byte of a pixel goes from the taken input request through the
//   front's register, a queue slot and then the output register to m_axis.
// - A queue of QUEUE_DEPTH pixels lets the front keep taking pixels while the
//   back end works or the receiver stalls; m_axis holds its request while
//   m_axis_tready is low and s_axis_tready drops once the queue and the front's register fill.
// - Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
//   and must be made only while the block is idle; the block does not enforce it.
// - Reset clears the column and row counters to the frame's top left corner,
//   empties the queue and loads the register defaults (640x480, 8 bpp, pitch
//   1024, base 0).

module gray_raster_pixel_writer import grpw_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ADDR_W-1:0]      cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [GRAY_W-1:0]      s_axis_tdata,   // [7:0] gray_level
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [29:0] byte_address, [37:30] byte_value
  output logic                   m_axis_tlast,   // last_of_pixel
  output logic                   m_axis_tuser    // end_of_frame
);

  cfg_t              cfg_q;
  logic              cmd_valid, cmd_ready, q_valid, q_ready;
  pix_cmd_t          cmd, q_cmd;
  logic [ADDR_W-1:0] out_addr;
  logic [BYTE_W-1:0] out_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base   <= BASE_RST;
      cfg_q.pitch  <= PITCH_RST;
      cfg_q.width  <= WIDTH_RST;
      cfg_q.height <= HEIGHT_RST;
      cfg_q.bpp    <= BPP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_ADDRESS:   cfg_q.base   <= cfg_data_i;
        REG_LINE_PITCH:     cfg_q.pitch  <= cfg_data_i[PITCH_W-1:0];
        REG_FRAME_WIDTH:    cfg_q.width  <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT:   cfg_q.height <= cfg_data_i[DIM_W-1:0];
        REG_BITS_PER_PIXEL: cfg_q.bpp    <= cfg_data_i[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  grpw_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pix_valid_i(s_axis_tvalid),
    .pix_ready_o(s_axis_tready),
    .pix_gray_i (s_axis_tdata),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  grpw_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(cmd_valid),
    .push_ready_o(cmd_ready),
    .push_data_i (cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_cmd)
  );

  grpw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_ready_o(q_ready),
    .cmd_i      (q_cmd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_addr_o (out_addr),
    .out_byte_o (out_byte),
    .out_last_o (m_axis_tlast),
    .out_eof_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - ADDR_W - BYTE_W){1'b0}}, out_byte, out_addr};

endmodule
